// ===== src/b32d_pkg.sv =====
// shared types, constants and the character classifier for the base32 stream decoder
package b32d_pkg;

	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = QPTR_W + 1;
	localparam int unsigned SYM_W   = 5;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned STORE_W = 7;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned ACC_W   = STORE_W + SYM_W;

	typedef struct packed {
		logic [SYM_W-1:0] value;
		logic             bad;
		logic             last;
	} sym_t;

	typedef struct packed {
		logic  push;
		sym_t  sym;
	} wr_t;

	typedef struct packed {
		logic  avail;
		sym_t  sym;
	} rd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              has_byte;
		logic              bad_symbol;
		logic              end_of_message;
	} result_t;

	function automatic sym_t classify(logic [7:0] ch, logic last);
		sym_t       s;
		logic [7:0] d;
		d      = 8'd0;
		s.bad  = 1'b0;
		s.last = last;
		case (ch) inside
			[8'h30:8'h39]: d = ch - 8'd48;
			[8'h41:8'h48]: d = ch - 8'd55;
			[8'h4A:8'h4B]: d = ch - 8'd56;
			[8'h4D:8'h4E]: d = ch - 8'd57;
			[8'h50:8'h54]: d = ch - 8'd58;
			[8'h56:8'h5A]: d = ch - 8'd59;
			default:       s.bad = 1'b1;
		endcase
		s.value = d[SYM_W-1:0];
		return s;
	endfunction

endpackage

// ===== src/b32d_in_if.sv =====
// character channel: valid/ready with symbol and last
interface b32d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

// ===== src/b32d_out_if.sv =====
// result channel: valid/ready with decoded byte and status flags
interface b32d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       bad_symbol;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte, output bad_symbol,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input has_byte, input bad_symbol,
		input end_of_message, output ready);
endinterface

// ===== src/b32d_front.sv =====
// front end: accepts characters and maps them to 5-bit values or a bad flag
module b32d_front (
	b32d_in_if.sink       enc,
	input  logic          q_full,
	output b32d_pkg::wr_t wr
);
	import b32d_pkg::*;

	assign enc.ready = !q_full;
	assign wr.push   = enc.valid && !q_full;
	assign wr.sym    = classify(enc.symbol, enc.last);

endmodule

// ===== src/b32d_queue.sv =====
// small register queue between the classifier and the bit accumulator
module b32d_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  b32d_pkg::wr_t wr,
	input  logic          pop,
	output logic          full,
	output b32d_pkg::rd_t rd
);
	import b32d_pkg::*;

	sym_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full     = count_q == QCNT_W'(QDEPTH);
	assign rd.avail = count_q != '0;
	assign rd.sym   = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd.avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!wr.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.sym;
		end
	end

endmodule

// ===== src/b32d_back.sv =====
// back end: gathers 5-bit groups into bytes, tracks errors, holds the result register
module b32d_back (
	input  logic          clk,
	input  logic          arst_n,
	input  b32d_pkg::rd_t rd,
	output logic          pop,
	b32d_out_if.source    dec
);
	import b32d_pkg::*;

	logic [STORE_W-1:0] store_q;
	logic [CNT_W-1:0]   count_q;
	logic               err_q;
	logic               valid_q;
	result_t            res_q;

	logic [ACC_W-1:0]   acc;
	logic [CNT_W:0]     cnt_sum;
	logic [CNT_W:0]     cnt_new;
	logic               has;
	logic [ACC_W-1:0]   shifted;
	logic [STORE_W-1:0] store_new;
	logic [STORE_W-1:0] store_d;
	logic [CNT_W-1:0]   count_d;
	logic               err_d;
	logic               emit;
	result_t            res;

	assign pop = rd.avail && (!valid_q || dec.ready);

	always_comb begin
		acc     = {store_q, rd.sym.value};
		cnt_sum = {1'b0, count_q} + (CNT_W+1)'(SYM_W);
		has     = cnt_sum >= (CNT_W+1)'(BYTE_W);
		cnt_new = has ? cnt_sum - (CNT_W+1)'(BYTE_W) : cnt_sum;
		shifted = acc >> cnt_new;
		for (int i = 0; i < STORE_W; i++) begin
			store_new[i] = acc[i] && ((CNT_W+1)'(i) < cnt_new);
		end

		store_d = store_q;
		count_d = count_q;
		err_d   = err_q;
		emit    = 1'b0;
		res     = '0;
		if (pop) begin
			if (err_q) begin
				if (rd.sym.last) begin
					emit               = 1'b1;
					res.bad_symbol     = 1'b1;
					res.end_of_message = 1'b1;
					store_d            = '0;
					count_d            = '0;
					err_d              = 1'b0;
				end
			end else if (rd.sym.bad) begin
				emit               = 1'b1;
				res.bad_symbol     = 1'b1;
				res.end_of_message = rd.sym.last;
				if (rd.sym.last) begin
					store_d = '0;
					count_d = '0;
				end else begin
					err_d = 1'b1;
				end
			end else begin
				store_d            = store_new;
				count_d            = cnt_new[CNT_W-1:0];
				emit               = has || rd.sym.last;
				res.data_byte      = has ? shifted[BYTE_W-1:0] : '0;
				res.has_byte       = has;
				res.end_of_message = rd.sym.last;
				if (rd.sym.last) begin
					store_d = '0;
					count_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			count_q <= '0;
			err_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			store_q <= store_d;
			count_q <= count_d;
			err_q   <= err_d;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (dec.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	assign dec.valid          = valid_q;
	assign dec.data_byte      = res_q.data_byte;
	assign dec.has_byte       = res_q.has_byte;
	assign dec.bad_symbol     = res_q.bad_symbol;
	assign dec.end_of_message = res_q.end_of_message;

endmodule

// ===== src/base32_stream_decoder.sv =====
// top level of the streaming crockford base32 decoder
// Takes one character per cycle and sustains that rate indefinitely when the result side is
// ready. A character is classified on transfer and placed in a four-entry queue; the back end
// takes one queued character per cycle, shifts its 5 bits into the bit store and, when a byte
// is complete, a bad character is found or the message ends, loads the output register. The
// output register loads at the same edge at which the character leaves the queue. Ready on the input drops
// only when the queue is full; the back end stalls only while an unaccepted result sits in the
// output register.
module base32_stream_decoder (
	input logic        clk,
	input logic        arst_n,
	b32d_in_if.sink    enc,
	b32d_out_if.source dec
);
	import b32d_pkg::*;

	wr_t  wr;
	rd_t  rd;
	logic q_full;
	logic pop;

	b32d_front u_front (
		.enc    (enc),
		.q_full (q_full),
		.wr     (wr)
	);

	b32d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.full   (q_full),
		.rd     (rd)
	);

	b32d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.pop    (pop),
		.dec    (dec)
	);

	a_bad_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && dec.bad_symbol |-> !dec.has_byte)
		else $error("bad symbol result carries a byte");

	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && !dec.has_byte |-> dec.data_byte == 8'd0)
		else $error("data byte nonzero without has_byte");

	a_error_then_bad: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && dec.ready && dec.bad_symbol && !dec.end_of_message
		|=> !dec.valid || dec.bad_symbol)
		else $error("result after an error is not the closing bad result");

endmodule

// ===== test/base32_stream_decoder_tb.sv =====
// testbench for base32_stream_decoder: directed table and random messages against a predictor
`timescale 1ns / 100ps

module base32_stream_decoder_tb;
	import b32d_pkg::result_t;

	localparam logic [255:0] CROCKFORD_ALPHABET = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 48;
	localparam int DRAIN_WAIT  = 8;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
		logic       typed;
		logic       emits;
		result_t    res;
	} stim_row_t;

	// rows with typed = 1 carry their result, the rest go through the predictor
	localparam stim_row_t DIRECTED [25] = '{
		'{8'h30, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
		'{"Z",   1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"Z",   1'b1, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b1}},
		'{"0",   1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"0",   1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
		'{"a",   1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
		'{"Z",   1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{"Z",   1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{"Z",   1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
		'{"I",   1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
		'{"U",   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{"7",   1'b0, 1'b0, 1'b0, '0},
		'{"H",   1'b0, 1'b0, 1'b0, '0},
		'{"3",   1'b0, 1'b0, 1'b0, '0},
		'{"K",   1'b0, 1'b0, 1'b0, '0},
		'{"Q",   1'b0, 1'b0, 1'b0, '0},
		'{"W",   1'b0, 1'b0, 1'b0, '0},
		'{"9",   1'b0, 1'b0, 1'b0, '0},
		'{"Y",   1'b1, 1'b0, 1'b0, '0},
		'{"X",   1'b0, 1'b0, 1'b0, '0},
		'{"G",   1'b1, 1'b0, 1'b0, '0},
		'{"/",   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{"[",   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n;

	b32d_in_if  enc_bus ();
	b32d_out_if dec_bus ();

	base32_stream_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc_bus),
		.dec    (dec_bus)
	);

	result_t    pending_results[$];
	logic [6:0] dec_store;
	logic [2:0] dec_count;
	logic       dec_error;
	int         err_count    = 0;
	int         chars_sent   = 0;
	int         src_idle_pct = 0;
	int         sink_idle_pct = 0;
	int         phase        = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void decode_step(input logic [7:0] ch, input logic lst,
		output bit emits, output result_t r);
		logic [4:0]  v;
		bit          bad;
		logic [11:0] acc;
		int unsigned n;
		emits = 1'b0;
		r     = '0;
		if (dec_error) begin
			if (lst) begin
				emits            = 1'b1;
				r.bad_symbol     = 1'b1;
				r.end_of_message = 1'b1;
				dec_store = '0;
				dec_count = '0;
				dec_error = 1'b0;
			end
			return;
		end
		bad = 1'b1;
		v   = '0;
		for (int k = 0; k < 32; k++) begin
			if (CROCKFORD_ALPHABET[8*(31-k) +: 8] == ch) begin
				bad = 1'b0;
				v   = k[4:0];
			end
		end
		if (bad) begin
			emits            = 1'b1;
			r.bad_symbol     = 1'b1;
			r.end_of_message = lst;
			if (lst) begin
				dec_store = '0;
				dec_count = '0;
			end else begin
				dec_error = 1'b1;
			end
			return;
		end
		acc = {dec_store, v};
		n   = dec_count + 5;
		if (n >= 8) begin
			n           = n - 8;
			r.data_byte = 8'(acc >> n);
			r.has_byte  = 1'b1;
		end
		dec_store = 7'(acc & ((12'd1 << n) - 12'd1));
		dec_count = 3'(n);
		if (lst) begin
			r.end_of_message = 1'b1;
			emits            = 1'b1;
			dec_store = '0;
			dec_count = '0;
		end else begin
			emits = r.has_byte;
		end
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic lst, input bit typed,
		input bit fixed_emits, input result_t fixed_res);
		bit      got;
		result_t res;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			enc_bus.valid <= 1'b0;
			@(posedge clk);
		end
		enc_bus.valid  <= 1'b1;
		enc_bus.symbol <= ch;
		enc_bus.last   <= lst;
		@(posedge clk);
		while (!enc_bus.ready) @(posedge clk);
		chars_sent++;
		decode_step(ch, lst, got, res);
		if (typed) begin
			got = fixed_emits;
			res = fixed_res;
		end
		if (got) pending_results.push_back(res);
	endtask

	task automatic send_random_message();
		int         len;
		bit         noisy;
		logic [7:0] ch;
		len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		noisy = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(0, 99) < 15) begin
				if ($urandom_range(0, 1) == 1) ch = 8'($urandom_range(0, 255));
				else ch = 8'($urandom_range(8'h61, 8'h7A));
			end else begin
				ch = CROCKFORD_ALPHABET[8*(31 - $urandom_range(0, 31)) +: 8];
			end
			send_char(ch, i == len - 1, 1'b0, 1'b0, '0);
		end
	endtask

	task automatic wait_for_results();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// result side: ready pattern and checking
	initial begin : result_sink
		result_t want;
		int      hold_left;
		bit      hold_done;
		hold_left     = 0;
		hold_done     = 1'b0;
		dec_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (dec_bus.valid && dec_bus.ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: data_byte %0h has_byte %0b bad_symbol %0b eom %0b",
						dec_bus.data_byte, dec_bus.has_byte, dec_bus.bad_symbol,
						dec_bus.end_of_message);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (dec_bus.data_byte !== want.data_byte) begin
						$error("data_byte: expected %0h, got %0h", want.data_byte,
							dec_bus.data_byte);
						err_count++;
					end
					if (dec_bus.has_byte !== want.has_byte) begin
						$error("has_byte: expected %0b, got %0b", want.has_byte,
							dec_bus.has_byte);
						err_count++;
					end
					if (dec_bus.bad_symbol !== want.bad_symbol) begin
						$error("bad_symbol: expected %0b, got %0b", want.bad_symbol,
							dec_bus.bad_symbol);
						err_count++;
					end
					if (dec_bus.end_of_message !== want.end_of_message) begin
						$error("end_of_message: expected %0b, got %0b", want.end_of_message,
							dec_bus.end_of_message);
						err_count++;
					end
				end
			end
			if (phase == 2 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				dec_bus.ready <= 1'b0;
			end else begin
				dec_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// ends the run when no transfer happens for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if ((enc_bus.valid && enc_bus.ready) || (dec_bus.valid && dec_bus.ready)) quiet = 0;
				else quiet++;
				if (quiet >= STALL_LIMIT) begin
					$display("[base32_stream_decoder] ERROR");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		enc_bus.valid  = 1'b0;
		enc_bus.symbol = 8'h00;
		enc_bus.last   = 1'b0;
		arst_n         = 1'b0;
		dec_store      = '0;
		dec_count      = '0;
		dec_error      = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 27;
		sink_idle_pct = 69;
		foreach (DIRECTED[i])
			send_char(DIRECTED[i].ch, DIRECTED[i].lst, DIRECTED[i].typed, DIRECTED[i].emits,
				DIRECTED[i].res);
		while (chars_sent < 170) send_random_message();
		enc_bus.valid <= 1'b0;
		wait_for_results();

		phase         = 1;
		src_idle_pct  = 69;
		sink_idle_pct = 27;
		while (chars_sent < 340) send_random_message();
		enc_bus.valid <= 1'b0;
		wait_for_results();

		// receiver holds off at the start of this phase while characters keep coming
		phase         = 2;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		while (chars_sent < 510) send_random_message();
		enc_bus.valid <= 1'b0;
		wait_for_results();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (err_count == 0 && pending_results.size() == 0) begin
			$display("[base32_stream_decoder] OK");
		end else begin
			$display("[base32_stream_decoder] ERROR");
		end
		$finish;
	end

endmodule
